FILE: hdl/iou_pkg.sv
package iou_pkg;

    localparam int TableDepthDefault = 32;
    localparam int IdLimitDefault    = 250;

    localparam int CoordW = 12;
    localparam int ClassW = 7;
    localparam int IdW    = 8;
    localparam int CountW = 8;

    localparam logic [7:0] ThresholdReset = 8'd77;
    localparam logic [7:0] MaxLostReset   = 8'd30;

    // configuration register indexes
    localparam logic [0:0] RegThreshold = 1'b0;
    localparam logic [0:0] RegMaxLost   = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the input item
        logic scan;      // read the entry at the scan index
        logic eval;      // compare the entry fetched in the previous cycle
        logic clear_idx; // restart the scan index
        logic advance;   // step the scan index
        logic age;       // apply end-of-frame aging to the fetched entry
        logic commit;    // write match or new entry and build the result
        logic id_scan;   // test one recycled ID slot, step past a miss
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
        logic id_hit;
        logic id_last;
        logic mode;
        logic found;
        logic full;
    } t_status;

endpackage

FILE: hdl/iou_instance_tracker.sv
// Greedy IoU instance tracker. Each detection item (i_mode 0) walks the
// whole instance table once through one shared overlap unit, one entry per
// cycle, with a two-stage compare (multiply, then cross-multiplied compare);
// an unmatched detection that finds a free entry then walks the recycled-ID
// map one ID per cycle, stopping at a recycled ID or at the end of the map.
// The result is registered as the match or new entry is committed. An
// end-of-frame item (i_mode 1) ages the table in one walk and gives no
// result. One item is worked at a time, and a result that is not taken
// holds off the next item.
// Registers: 0 match threshold (byte 0x0), 1 lost-frame limit (byte 0x4).
module iou_instance_tracker #(
    parameter int TABLE_DEPTH = iou_pkg::TableDepthDefault,
    parameter int ID_LIMIT    = iou_pkg::IdLimitDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [6:0]  i_class_id,
    input  logic [11:0] i_box_x,
    input  logic [11:0] i_box_y,
    input  logic [11:0] i_box_w,
    input  logic [11:0] i_box_h,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_global_id,
    output logic        o_is_new,
    output logic        o_table_full
);

    logic [7:0] r_threshold, r_max_lost;
    iou_pkg::t_cmd    cmd;
    iou_pkg::t_status status;

    assign pready = 1'b1;

    // register file: writes land on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= iou_pkg::ThresholdReset;
            r_max_lost  <= iou_pkg::MaxLostReset;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == iou_pkg::RegThreshold && paddr[1:0] == 2'b00) begin
                r_threshold <= pwdata[7:0];
            end else if (paddr[2] == iou_pkg::RegMaxLost && paddr[1:0] == 2'b00) begin
                r_max_lost <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        case (paddr[2])
            iou_pkg::RegThreshold: prdata = {24'd0, r_threshold};
            iou_pkg::RegMaxLost:   prdata = {24'd0, r_max_lost};
            default:               prdata = '0;
        endcase
    end

    iou_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    iou_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_LIMIT    (ID_LIMIT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_threshold  (r_threshold),
        .i_max_lost   (r_max_lost),
        .i_mode       (i_mode),
        .i_class_id   (i_class_id),
        .i_box_x      (i_box_x),
        .i_box_y      (i_box_y),
        .i_box_w      (i_box_w),
        .i_box_h      (i_box_h),
        .o_global_id  (o_global_id),
        .o_is_new     (o_is_new),
        .o_table_full (o_table_full)
    );

endmodule

FILE: hdl/iou_ctrl.sv
module iou_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    input  iou_pkg::t_status i_status,
    output iou_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] StIdle   = 3'd0;
    localparam logic [2:0] StScan   = 3'd1;
    localparam logic [2:0] StDrain  = 3'd2;
    localparam logic [2:0] StIdSrc  = 3'd3;
    localparam logic [2:0] StDone   = 3'd4;
    localparam logic [2:0] StOut    = 3'd5;
    localparam logic [2:0] StSettle = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic       r_prev_scan;

    assign o_valid = r_ovalid;
    assign o_ready = (r_state == StIdle) && !r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            StIdle: begin
                if (i_valid && o_ready) begin
                    o_cmd.load      = 1'b1;
                    o_cmd.clear_idx = 1'b1;
                    n_state         = StScan;
                end
            end
            StScan: begin
                o_cmd.scan    = 1'b1;
                o_cmd.advance = 1'b1;
                if (i_status.scan_last) begin
                    n_state = StDrain;
                end
            end
            StDrain: begin
                // last fetched entry is evaluated here
                if (i_status.mode) begin
                    n_state = StIdle;
                end else begin
                    n_state = StSettle;
                end
            end
            StSettle: begin
                // compare of the last entry lands here
                if (i_status.found || i_status.full) begin
                    n_state = StDone;
                end else begin
                    n_state = StIdSrc;
                end
            end
            StIdSrc: begin
                o_cmd.id_scan = 1'b1;
                if (i_status.id_hit || i_status.id_last) begin
                    n_state = StDone;
                end
            end
            StDone: begin
                o_cmd.commit = 1'b1;
                n_ovalid     = 1'b1;
                n_state      = StOut;
            end
            StOut: begin
                if (!r_ovalid || i_ready) begin
                    n_state = StIdle;
                end
            end
            default: n_state = StIdle;
        endcase
        // the fetched entry is registered, so it lags the scan index
        if (r_state == StScan && r_prev_scan) begin
            o_cmd.eval = !i_status.mode;
            o_cmd.age  = i_status.mode;
        end
        if (r_state == StDrain) begin
            o_cmd.eval = !i_status.mode;
            o_cmd.age  = i_status.mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StIdle;
            r_ovalid    <= 1'b0;
            r_prev_scan <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ovalid    <= n_ovalid;
            r_prev_scan <= (r_state == StScan);
        end
    end

    a_out_only_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == StDone)
        else $error("result raised outside commit");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == StIdle)
        else $error("ready while busy");
    a_commit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> !o_cmd.commit)
        else $error("double commit");

endmodule

FILE: hdl/iou_dp.sv
module iou_dp #(
    parameter int TABLE_DEPTH = iou_pkg::TableDepthDefault,
    parameter int ID_LIMIT    = iou_pkg::IdLimitDefault
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  iou_pkg::t_cmd             i_cmd,
    output iou_pkg::t_status          o_status,
    input  logic [7:0]                i_threshold,
    input  logic [7:0]                i_max_lost,
    input  logic                      i_mode,
    input  logic [iou_pkg::ClassW-1:0] i_class_id,
    input  logic [iou_pkg::CoordW-1:0] i_box_x,
    input  logic [iou_pkg::CoordW-1:0] i_box_y,
    input  logic [iou_pkg::CoordW-1:0] i_box_w,
    input  logic [iou_pkg::CoordW-1:0] i_box_h,
    output logic [iou_pkg::IdW-1:0]   o_global_id,
    output logic                      o_is_new,
    output logic                      o_table_full
);

    localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IdmW = $clog2(ID_LIMIT);
    localparam int CW   = iou_pkg::CoordW;
    localparam int AW   = 2 * (CW + 1);   // area width
    localparam int UW   = AW + 1;

    // per-entry flags in flops; payload in memory
    logic [TABLE_DEPTH-1:0] r_valid, r_matched, r_pending;
    logic [iou_pkg::ClassW-1:0] m_class [TABLE_DEPTH];
    logic [4*CW-1:0]            m_box   [TABLE_DEPTH];
    logic [iou_pkg::CountW-1:0] m_lost  [TABLE_DEPTH];
    logic [iou_pkg::IdW-1:0]    m_id    [TABLE_DEPTH];
    logic [ID_LIMIT-1:0]        r_recyc;
    logic [iou_pkg::IdW-1:0]    r_fresh;

    logic                       r_mode;
    logic [iou_pkg::ClassW-1:0] r_class;
    logic [CW-1:0]              r_bx, r_by, r_bw, r_bh;

    logic [IdxW:0]  r_idx;
    logic [IdxW-1:0] r_ridx;
    logic [iou_pkg::ClassW-1:0] r_rclass;
    logic [4*CW-1:0]            r_rbox;
    logic [iou_pkg::CountW-1:0] r_rlost;
    logic [iou_pkg::IdW-1:0]    r_rid;

    logic                       r_found;
    logic [IdxW-1:0]            r_best;
    logic [AW-1:0]              r_best_i;
    logic [UW-1:0]              r_best_u;
    logic                       r_free_ok;
    logic [IdxW-1:0]            r_free;
    logic [IdmW:0]              r_kid;
    logic                       r_id_hit;

    // stage-1 overlap of the detection and the fetched entry
    logic [CW:0]   ax2, ay2, bx2, by2, x1, y1, x2, y2;
    logic [CW:0]   iw, ih;
    logic [CW-1:0] ex, ey, ew, eh;
    logic          cand;

    assign ex = r_rbox[4*CW-1 -: CW];
    assign ey = r_rbox[3*CW-1 -: CW];
    assign ew = r_rbox[2*CW-1 -: CW];
    assign eh = r_rbox[CW-1 -: CW];

    always_comb begin
        ax2 = {1'b0, r_bx} + {1'b0, r_bw};
        ay2 = {1'b0, r_by} + {1'b0, r_bh};
        bx2 = {1'b0, ex} + {1'b0, ew};
        by2 = {1'b0, ey} + {1'b0, eh};
        x1  = (r_bx > ex) ? {1'b0, r_bx} : {1'b0, ex};
        y1  = (r_by > ey) ? {1'b0, r_by} : {1'b0, ey};
        x2  = (ax2 < bx2) ? ax2 : bx2;
        y2  = (ay2 < by2) ? ay2 : by2;
        iw  = (x2 > x1) ? x2 - x1 : '0;
        ih  = (y2 > y1) ? y2 - y1 : '0;
        cand = r_valid[r_ridx] && !r_pending[r_ridx] && !r_matched[r_ridx]
            && (r_rclass == r_class);
    end

    // overlap products registered, then compared next cycle
    logic [AW-1:0] p_inter, p_a1, p_a2;
    logic          p_cand, p_ev;
    logic [IdxW-1:0] p_idx;
    logic [UW-1:0] uni;
    logic [AW+8:0] lhs, rhs;
    logic [AW+UW-1:0] cx_a, cx_b;
    logic          pass, better;

    always_comb begin
        uni    = {1'b0, p_a1} + {1'b0, p_a2} - {1'b0, p_inter};
        lhs    = {1'b0, p_inter, 8'd0};
        rhs    = (AW+9)'(i_threshold) * (AW+9)'(uni);
        pass   = lhs > rhs;
        cx_a   = (AW+UW)'(p_inter) * (AW+UW)'(r_best_u);
        cx_b   = (AW+UW)'(r_best_i) * (AW+UW)'(uni);
        better = !r_found || (cx_a > cx_b);
    end

    logic [IdxW:0] last_idx;
    assign last_idx = (IdxW+1)'(TABLE_DEPTH - 1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_class <= i_class_id;
            r_bx <= i_box_x;  r_by <= i_box_y;
            r_bw <= i_box_w;  r_bh <= i_box_h;
        end
        if (i_cmd.scan) begin
            r_ridx   <= r_idx[IdxW-1:0];
            r_rclass <= m_class[r_idx[IdxW-1:0]];
            r_rbox   <= m_box[r_idx[IdxW-1:0]];
            r_rlost  <= m_lost[r_idx[IdxW-1:0]];
            r_rid    <= m_id[r_idx[IdxW-1:0]];
        end
        p_inter <= AW'(iw) * AW'(ih);
        p_a1    <= AW'(r_bw) * AW'(r_bh);
        p_a2    <= AW'(ew) * AW'(eh);
        p_idx   <= r_ridx;
    end

    logic [iou_pkg::CountW-1:0] lost_inc;
    assign lost_inc = (r_rlost == 8'hFF) ? r_rlost : r_rlost + 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_matched <= '0;
            r_pending <= '0;
            r_recyc   <= '0;
            r_fresh   <= 8'd1;
            r_idx     <= '0;
            r_found   <= 1'b0;
            r_free_ok <= 1'b0;
            p_cand    <= 1'b0;
            p_ev      <= 1'b0;
            r_kid     <= '0;
            r_id_hit  <= 1'b0;
        end else begin
            p_ev   <= i_cmd.eval;
            p_cand <= cand;
            if (i_cmd.clear_idx) begin
                r_idx     <= '0;
                r_found   <= 1'b0;
                r_free_ok <= 1'b0;
                r_kid     <= (IdmW+1)'(1);
                r_id_hit  <= 1'b0;
            end else if (i_cmd.advance) begin
                r_idx <= r_idx + 1'b1;
            end
            // free slot search during the detection scan
            if (i_cmd.eval && !r_valid[r_ridx] && !r_free_ok) begin
                r_free_ok <= 1'b1;
                r_free    <= r_ridx;
            end
            if (p_ev && p_cand && pass && better) begin
                r_found  <= 1'b1;
                r_best   <= p_idx;
                r_best_i <= p_inter;
                r_best_u <= uni;
            end
            if (i_cmd.age && r_valid[r_ridx]) begin
                if (r_pending[r_ridx]) begin
                    r_pending[r_ridx] <= 1'b0;
                    r_matched[r_ridx] <= 1'b0;
                end else if (r_matched[r_ridx]) begin
                    r_matched[r_ridx] <= 1'b0;
                end else if (lost_inc > i_max_lost) begin
                    r_valid[r_ridx] <= 1'b0;
                    if (r_rid != '0 && 32'(r_rid) < ID_LIMIT) begin
                        r_recyc[r_rid[IdmW-1:0]] <= 1'b1;
                    end
                end
            end
            if (i_cmd.id_scan && !r_id_hit) begin
                if (r_recyc[r_kid[IdmW-1:0]]) begin
                    r_id_hit <= 1'b1;
                end else begin
                    r_kid <= r_kid + 1'b1;
                end
            end
            if (i_cmd.commit) begin
                if (r_found) begin
                    r_matched[r_best] <= 1'b1;
                end else if (r_free_ok) begin
                    r_valid[r_free]   <= 1'b1;
                    r_pending[r_free] <= 1'b1;
                    r_matched[r_free] <= 1'b0;
                    if (r_id_hit) begin
                        r_recyc[r_kid[IdmW-1:0]] <= 1'b0;
                    end else begin
                        r_fresh <= (32'(r_fresh) + 1 >= ID_LIMIT) ? 8'd1 : r_fresh + 8'd1;
                    end
                end
            end
        end
    end

    logic [iou_pkg::IdW-1:0] new_id;
    assign new_id = r_id_hit ? iou_pkg::IdW'(r_kid) : r_fresh;

    // payload memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.age && r_valid[r_ridx] && !r_pending[r_ridx] && !r_matched[r_ridx]) begin
            m_lost[r_ridx] <= lost_inc;
        end
        if (i_cmd.commit) begin
            if (r_found) begin
                m_box[r_best]  <= {r_bx, r_by, r_bw, r_bh};
                m_lost[r_best] <= '0;
                o_global_id    <= m_id[r_best];
                o_is_new       <= 1'b0;
                o_table_full   <= 1'b0;
            end else if (r_free_ok) begin
                m_class[r_free] <= r_class;
                m_box[r_free]   <= {r_bx, r_by, r_bw, r_bh};
                m_lost[r_free]  <= '0;
                m_id[r_free]    <= new_id;
                o_global_id     <= new_id;
                o_is_new        <= 1'b1;
                o_table_full    <= 1'b0;
            end else begin
                o_global_id  <= '0;
                o_is_new     <= 1'b0;
                o_table_full <= 1'b1;
            end
        end
    end

    assign o_status.scan_last = (r_idx == last_idx);
    assign o_status.id_hit    = r_id_hit || (i_cmd.id_scan && r_recyc[r_kid[IdmW-1:0]]);
    assign o_status.id_last   = (32'(r_kid) >= ID_LIMIT - 1);
    assign o_status.mode      = r_mode;
    assign o_status.found     = r_found || (p_ev && p_cand && pass);
    assign o_status.full      = !r_free_ok;

endmodule
